/* rtl/core/assert_macros.svh */
// assertion macros used by the port-level checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is low
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked through reset as well
`define ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/adl_pkg.sv */
// types, codes and constants of the adler-32 frame checker
// no dependencies
`timescale 1ns / 1ps

package adl_pkg;

    localparam int unsigned ADLER_MOD          = 65521;
    localparam int unsigned MIN_FRAME_LEN      = 8;
    localparam int unsigned MIN_NAME_LEN       = 2;
    localparam int unsigned P_QUEUE_DEPTH_DEF  = 4;
    localparam int unsigned CFG_W              = 31;
    localparam int unsigned OUT_TDATA_W        = 104;

    // register indexes of the configuration port
    localparam logic CFG_MIN_LEN = 1'b0;
    localparam logic CFG_MAX_LEN = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEN  = 2'd1;
    localparam logic [1:0] ST_BAD_SUM  = 2'd2;
    localparam logic [1:0] ST_BAD_NAME = 2'd3;

    // token kinds between front and back
    localparam logic [1:0] K_BODY    = 2'd0;
    localparam logic [1:0] K_HDR_OK  = 2'd1;
    localparam logic [1:0] K_HDR_BAD = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic        name_byte;
        logic        sum_byte;
        logic        last_byte;
        logic [31:0] data;
    } t_token;

endpackage

/* rtl/core/adler32_framed_message_checker.sv */
// top level of the length-prefixed frame checker with adler-32 trailer
// depends on adl_pkg, adl_front, adl_queue, adl_back
//
//  channel   direction  width  contents
//  s_axis    in         8      one raw stream byte per transaction
//  m_axis    out        104    one status per finished frame
//  cfg       in         31     write-only min and max body length
//
//  throughput is one byte per cycle while the queue has room; the front classifies a byte
//  in the cycle it is accepted and the back folds it into the adler sums through the queue
//  a frame's status is registered once its last byte, or its rejected header, leaves the queue
//  reset is synchronous, active low; it clears the phase, queue, sums and the status valid flag
//  a stalled status only holds back the bytes behind it once the queue is full
`timescale 1ns / 1ps

module adler32_framed_message_checker import adl_pkg::*; #(
    parameter int unsigned P_QUEUE_DEPTH = P_QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // byte stream in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // data_byte
    // status out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status [1:0], frame_length [33:2], name_length [65:34],
    // computed_checksum [97:66], zero pad [103:98]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic   push;
    t_token push_token;
    logic   q_full;
    logic   q_valid;
    t_token q_head;
    logic   q_pop;

    // front: header shift, length window check, body byte tagging
    adl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_byte_valid (s_axis_tvalid),
        .i_byte       (s_axis_tdata),
        .i_q_full     (q_full),
        .o_byte_ready (s_axis_tready),
        .o_push       (push),
        .o_token      (push_token)
    );

    // decoupling queue, one token per body byte or header verdict
    adl_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (push_token),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // back: modular sums, trailer compare, name length rule, output register
    adl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_token  (q_head),
        .o_q_pop    (q_pop),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

/* rtl/core/adl_front.sv */
// front end: header parsing, length check and per-byte classification
// depends on adl_pkg
`timescale 1ns / 1ps

module adl_front import adl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_byte_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_q_full,
    output logic             o_byte_ready,
    output logic             o_push,
    output t_token           o_token
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_DEAD   = 2'd2;

    logic [1:0]       r_phase;
    logic [1:0]       r_hdr_cnt;
    logic [31:0]      r_hdr;
    logic [30:0]      r_left;
    logic [2:0]       r_name_cnt;
    logic [CFG_W-1:0] r_min_len;
    logic [CFG_W-1:0] r_max_len;

    logic        accept;
    logic [31:0] n_hdr;
    logic        len_bad;

    assign o_byte_ready = !i_q_full;
    assign accept       = i_byte_valid && !i_q_full;
    assign n_hdr        = {r_hdr[23:0], i_byte};

    // negative, too short for its fields, or outside the configured window
    assign len_bad = n_hdr[31]
                  || (n_hdr[30:0] < CFG_W'(MIN_FRAME_LEN))
                  || (n_hdr[30:0] < r_min_len)
                  || (n_hdr[30:0] > r_max_len);

    always_comb begin
        o_push  = 1'b0;
        o_token = '0;
        case (r_phase)
            PH_HEADER: begin
                o_token.data = n_hdr;
                o_token.kind = len_bad ? K_HDR_BAD : K_HDR_OK;
                o_push       = accept && (r_hdr_cnt == 2'd3);
            end
            PH_BODY: begin
                o_token.kind      = K_BODY;
                o_token.data      = {24'd0, i_byte};
                o_token.name_byte = (r_name_cnt != 3'd4);
                o_token.sum_byte  = (r_left > 31'd4);
                o_token.last_byte = (r_left == 31'd1);
                o_push            = accept;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_cnt  <= 2'd0;
            r_hdr      <= '0;
            r_left     <= '0;
            r_name_cnt <= '0;
            r_min_len  <= CFG_W'(10);
            r_max_len  <= CFG_W'(67108864);
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MIN_LEN: r_min_len <= i_cfg_data;
                    CFG_MAX_LEN: r_max_len <= i_cfg_data;
                    default:     r_min_len <= r_min_len;
                endcase
            end
            if (accept) begin
                case (r_phase)
                    PH_HEADER: begin
                        r_hdr     <= n_hdr;
                        r_hdr_cnt <= r_hdr_cnt + 2'd1;
                        if (r_hdr_cnt == 2'd3) begin
                            r_left     <= n_hdr[30:0];
                            r_name_cnt <= '0;
                            r_phase    <= len_bad ? PH_DEAD : PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        r_left <= r_left - 31'd1;
                        if (r_name_cnt != 3'd4) begin
                            r_name_cnt <= r_name_cnt + 3'd1;
                        end
                        if (r_left == 31'd1) begin
                            r_phase   <= PH_HEADER;
                            r_hdr_cnt <= 2'd0;
                        end
                    end
                    default: begin
                        r_phase <= PH_DEAD;
                    end
                endcase
            end
        end
    end

endmodule

/* rtl/core/adl_queue.sv */
// short token queue between front and back
// depends on adl_pkg
`timescale 1ns / 1ps

module adl_queue import adl_pkg::*; #(
    parameter int unsigned P_DEPTH = P_QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_token,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_token o_head
);

    localparam int unsigned AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CW = $clog2(P_DEPTH + 1);

    t_token          r_mem [P_DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/core/adl_back.sv */
// back end: adler-32 sums, trailer and name length capture, status register
// depends on adl_pkg
`timescale 1ns / 1ps

module adl_back import adl_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  t_token                 i_q_token,
    output logic                   o_q_pop,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic [15:0] r_lo;
    logic [15:0] r_hi;
    logic [31:0] r_trail;
    logic [31:0] r_name;
    logic [31:0] r_len;

    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [31:0] r_frame_out;
    logic [31:0] r_name_out;
    logic [31:0] r_sum_out;

    logic        is_result;
    logic        out_free;
    logic [7:0]  b;
    logic [16:0] lo_sum;
    logic [15:0] n_lo;
    logic [16:0] hi_sum;
    logic [15:0] n_hi;
    logic [31:0] n_trail;
    logic [31:0] n_name;
    logic [31:0] sum_now;
    logic        name_bad;
    logic [1:0]  body_status;

    always_comb begin
        is_result = (i_q_token.kind == K_HDR_BAD)
                 || ((i_q_token.kind == K_BODY) && i_q_token.last_byte);
        out_free  = !r_out_valid || i_m_tready;
        o_q_pop   = i_q_valid && (!is_result || out_free);

        b      = i_q_token.data[7:0];
        lo_sum = {1'b0, r_lo} + {9'd0, b};
        n_lo   = (lo_sum >= 17'(ADLER_MOD)) ? 16'(lo_sum - 17'(ADLER_MOD)) : lo_sum[15:0];
        hi_sum = {1'b0, r_hi} + {1'b0, n_lo};
        n_hi   = (hi_sum >= 17'(ADLER_MOD)) ? 16'(hi_sum - 17'(ADLER_MOD)) : hi_sum[15:0];

        n_trail = {r_trail[23:0], b};
        n_name  = {r_name[23:0], b};
        sum_now = {r_hi, r_lo};

        // name length must fit between its own field and the trailer
        name_bad = ($signed(r_name) < $signed(32'(MIN_NAME_LEN)))
                || ($signed({r_name[31], r_name})
                    > $signed({1'b0, r_len} - 33'(MIN_FRAME_LEN)));

        if (sum_now != n_trail) begin
            body_status = ST_BAD_SUM;
        end else if (name_bad) begin
            body_status = ST_BAD_NAME;
        end else begin
            body_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_lo        <= 16'd1;
            r_hi        <= '0;
            r_trail     <= '0;
            r_name      <= '0;
        end else begin
            if (o_q_pop && is_result) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (o_q_pop) begin
                case (i_q_token.kind)
                    K_HDR_OK: begin
                        r_len <= i_q_token.data;
                    end
                    K_HDR_BAD: begin
                        r_status    <= ST_BAD_LEN;
                        r_frame_out <= i_q_token.data;
                        r_name_out  <= '0;
                        r_sum_out   <= '0;
                    end
                    K_BODY: begin
                        if (i_q_token.name_byte) begin
                            r_name <= n_name;
                        end
                        if (i_q_token.sum_byte) begin
                            r_lo <= n_lo;
                            r_hi <= n_hi;
                        end else if (!i_q_token.last_byte) begin
                            r_trail <= n_trail;
                        end
                        if (i_q_token.last_byte) begin
                            r_status    <= body_status;
                            r_frame_out <= r_len;
                            r_name_out  <= r_name;
                            r_sum_out   <= sum_now;
                            r_lo        <= 16'd1;
                            r_hi        <= '0;
                            r_trail     <= '0;
                            r_name      <= '0;
                        end
                    end
                    default: begin
                        r_lo <= r_lo;
                    end
                endcase
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_sum_out, r_name_out, r_frame_out, r_status};

endmodule

/* rtl/core/adl_checker.sv */
// port-level checks on the frame checker, bound to the top level
// depends on adl_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adl_checker import adl_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic stalled;
    assign stalled = m_axis_tvalid && !m_axis_tready;

    `ASSERT_NXT(a_valid_holds, i_clk, i_rst_n, stalled, m_axis_tvalid)
    `ASSERT_NXT(a_data_holds, i_clk, i_rst_n, stalled, $stable(m_axis_tdata))
    `ASSERT_NXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !m_axis_tvalid)
    `ASSERT_IMP(a_bad_len_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[1:0] == ST_BAD_LEN), (m_axis_tdata[65:34] == '0) && (m_axis_tdata[97:66] == '0))
    `ASSERT_IMP(a_ok_len_pos, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[1:0] == ST_OK), !m_axis_tdata[33] && (m_axis_tdata[103:98] == '0))

endmodule

bind adler32_framed_message_checker adl_checker u_adl_checker (.*);

/* test/tb.sv */
// self-checking bench for the adler-32 framed message checker
// drives a byte stream of length-prefixed frames, predicts each status and compares
// depends on adl_pkg and adler32_framed_message_checker
`timescale 1ns / 1ps

module tb;
    import adl_pkg::*;

    localparam int unsigned HDR_BYTES    = 4;      // length field and name length field
    localparam int unsigned DRAIN_CYCLES = 10;     // status latency plus bytes still queued
    localparam int unsigned STALL_LIMIT  = 2000;   // cycles with no transaction or register write
    localparam int unsigned MAX_REPORTS  = 10;

    typedef enum logic [1:0] {FP_HEADER, FP_BODY, FP_DISCARD} frame_phase_e;
    typedef enum logic [1:0] {FILL_RAND, FILL_ZERO, FILL_ONES} fill_e;
    typedef enum logic {ROW_FRAME, ROW_LIMITS} row_e;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] frame_len;
        logic [31:0] name_len;
        logic [31:0] adler;
    } t_frame_status;

    // one directed step: a frame, or a new pair of length limits (blen = min, nlen = max)
    typedef struct packed {
        row_e        kind;
        logic [31:0] blen;
        logic [31:0] nlen;
        fill_e       fill;
        logic        spoil;
        logic        typed;
        logic [1:0]  status;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic                   i_cfg_index = CFG_MIN_LEN;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = 8'h00;     // data_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // status [1:0], frame_length [33:2], name_length [65:34], computed_checksum [97:66]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    adler32_framed_message_checker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // mirror of the length limits, reset values
    logic [CFG_W-1:0] lim_min = 31'd10;
    logic [CFG_W-1:0] lim_max = 31'd67108864;

    // predictor state for the frame in flight
    frame_phase_e chk_phase = FP_HEADER;
    int unsigned  chk_count = 0;
    logic [31:0]  chk_len   = '0;
    logic [31:0]  chk_hdr   = '0;
    logic [31:0]  chk_name  = '0;
    int unsigned  chk_lo    = 1;
    int unsigned  chk_hi    = 0;
    logic [31:0]  chk_trl   = '0;

    t_frame_status pending_status_q[$];
    logic [7:0]    frame_bytes[$];
    int            mismatches = 0;
    bit            calm = 1'b0;          // no idling on either side while set
    bit            tag_on = 1'b0;        // status of the current directed row is typed in
    logic [1:0]    tag_status = ST_OK;
    int unsigned   quiet_cycles = 0;

    // folds one accepted byte into the predicted frame state, returns 1 when a status is due
    function automatic bit predict_frame_status(input logic [7:0] b, output t_frame_status r);
        int          len_s;
        int          nl_s;
        logic [31:0] sum;
        r = '0;
        if (chk_phase == FP_HEADER) begin
            chk_hdr = {chk_hdr[23:0], b};
            chk_count++;
            if (chk_count == HDR_BYTES) begin
                chk_len = chk_hdr;
                len_s   = chk_hdr;
                // signed compare: a negative length is always out of bounds
                if (len_s < int'(MIN_FRAME_LEN) || len_s < int'(lim_min)
                        || len_s > int'(lim_max)) begin
                    r.status    = ST_BAD_LEN;
                    r.frame_len = chk_len;
                    chk_phase   = FP_DISCARD;
                    return 1'b1;
                end
                chk_phase = FP_BODY;
                chk_count = 0;
            end
            return 1'b0;
        end
        if (chk_phase == FP_BODY) begin
            if (chk_count < HDR_BYTES)
                chk_name = {chk_name[23:0], b};
            if (chk_count < chk_len - HDR_BYTES) begin
                chk_lo = chk_lo + b;
                if (chk_lo >= ADLER_MOD)
                    chk_lo -= ADLER_MOD;
                chk_hi = chk_hi + chk_lo;
                if (chk_hi >= ADLER_MOD)
                    chk_hi -= ADLER_MOD;
            end else begin
                chk_trl = {chk_trl[23:0], b};
            end
            chk_count++;
            if (chk_count == chk_len) begin
                sum   = {chk_hi[15:0], chk_lo[15:0]};
                nl_s  = chk_name;
                len_s = chk_len;
                // checksum outranks the name length rule
                if (sum != chk_trl)
                    r.status = ST_BAD_SUM;
                else if (nl_s < int'(MIN_NAME_LEN) || nl_s > len_s - 8)
                    r.status = ST_BAD_NAME;
                else
                    r.status = ST_OK;
                r.frame_len = chk_len;
                r.name_len  = chk_name;
                r.adler     = sum;
                chk_phase = FP_HEADER;
                chk_count = 0;
                chk_len   = '0;
                chk_hdr   = '0;
                chk_name  = '0;
                chk_lo    = 1;
                chk_hi    = 0;
                chk_trl   = '0;
                return 1'b1;
            end
        end
        // discard phase swallows everything
        return 1'b0;
    endfunction

    // one byte transaction, with valid now and then dropped in front of it unless calm is set
    task automatic send_byte(input logic [7:0] b);
        t_frame_status r;
        if (!calm && $urandom_range(99) < 12) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        if (predict_frame_status(b, r)) begin
            if (tag_on)
                r.status = tag_status;
            pending_status_q.push_back(r);
        end
    endtask

    task automatic send_bytes();
        foreach (frame_bytes[k])
            send_byte(frame_bytes[k]);
    endtask

    // header, name length, filler and trailer; a spoilt trailer has one bit flipped
    task automatic make_frame(input int unsigned blen, input logic [31:0] nlen,
                              input fill_e fill, input bit spoil);
        int unsigned lo;
        int unsigned hi;
        logic [31:0] chk;
        logic [31:0] len_w;
        logic [7:0]  b;
        lo    = 1;
        hi    = 0;
        len_w = blen;
        frame_bytes.delete();
        for (int k = 0; k < HDR_BYTES; k++)
            frame_bytes.push_back(len_w[31-8*k -: 8]);
        for (int unsigned k = 0; k < blen - HDR_BYTES; k++) begin
            if (k < HDR_BYTES)
                b = nlen[31-8*k -: 8];
            else
                case (fill)
                    FILL_ZERO: b = 8'h00;
                    FILL_ONES: b = 8'hFF;
                    default:   b = 8'($urandom);
                endcase
            frame_bytes.push_back(b);
            lo = (lo + b) % ADLER_MOD;
            hi = (hi + lo) % ADLER_MOD;
        end
        chk = {hi[15:0], lo[15:0]};
        if (spoil)
            chk ^= 32'h1 << $urandom_range(31);
        for (int k = 0; k < HDR_BYTES; k++)
            frame_bytes.push_back(chk[31-8*k -: 8]);
    endtask

    // limits change only with the block idle: all statuses back, queue drained
    task automatic set_limits(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        s_axis_tvalid <= 1'b0;
        while (pending_status_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_MIN_LEN;
        i_cfg_data  <= lo;
        lim_min = lo;
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_LEN;
        i_cfg_data  <= hi;
        lim_max = hi;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // well-formed frames with random content, a share of bad trailers and name lengths
    task automatic run_random(input int unsigned lo_len, input int unsigned hi_len,
                              input int unsigned budget);
        int unsigned sent;
        int unsigned cap;
        int unsigned blen;
        logic [31:0] nlen;
        fill_e       fill;
        sent = 0;
        while (sent < budget) begin
            // mostly short frames, now and then a long one so the low sum wraps
            if ($urandom_range(99) < 10)
                cap = (hi_len < 400) ? hi_len : 400;
            else
                cap = (hi_len < lo_len + 30) ? hi_len : lo_len + 30;
            blen = $urandom_range(cap, lo_len);
            if ($urandom_range(99) < 75)
                nlen = (blen >= 10) ? $urandom_range(blen - 8, MIN_NAME_LEN) : MIN_NAME_LEN;
            else
                case ($urandom_range(4))
                    0: nlen = 32'd0;
                    1: nlen = 32'd1;
                    2: nlen = blen - 7;
                    3: nlen = blen - 8;
                    default: nlen = $urandom;
                endcase
            case ($urandom_range(9))
                0: fill = FILL_ZERO;
                1: fill = FILL_ONES;
                default: fill = FILL_RAND;
            endcase
            make_frame(blen, nlen, fill, $urandom_range(99) < 15);
            send_bytes();
            sent += blen + HDR_BYTES;
        end
    endtask

    // ---------------------------------------------------------------
    // status side: random back-pressure, checked field by field
    // ---------------------------------------------------------------
    task automatic report_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("tb: %s mismatch, expected %h, got %h", what, want, got);
    endtask

    task automatic check_status(input logic [OUT_TDATA_W-1:0] d);
        t_frame_status want;
        if (pending_status_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("tb: status transaction with nothing expected, data %h", d);
        end else begin
            want = pending_status_q.pop_front();
            if (d[1:0] != want.status)
                report_field("status", 32'(want.status), 32'(d[1:0]));
            if (d[33:2] != want.frame_len)
                report_field("frame_length", want.frame_len, d[33:2]);
            if (d[65:34] != want.name_len)
                report_field("name_length", want.name_len, d[65:34]);
            if (d[97:66] != want.adler)
                report_field("computed_checksum", want.adler, d[97:66]);
        end
    endtask

    // values read here are the ones sampled at this edge
    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 12);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_status(m_axis_tdata);
    end

    // watchdog: any transaction or register write restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    t_row        dir_rows [0:16];
    logic [31:0] bad_len;

    initial begin
        dir_rows = '{
            // reset limits 10 .. 2^26
            '{ROW_FRAME, 32'd10, 32'd2,          FILL_ZERO, 1'b0, 1'b1, ST_OK},
            '{ROW_FRAME, 32'd10, 32'd2,          FILL_ONES, 1'b0, 1'b1, ST_OK},
            '{ROW_FRAME, 32'd16, 32'd8,          FILL_RAND, 1'b0, 1'b1, ST_OK},
            '{ROW_FRAME, 32'd16, 32'd9,          FILL_RAND, 1'b0, 1'b1, ST_BAD_NAME},
            '{ROW_FRAME, 32'd16, 32'd1,          FILL_RAND, 1'b0, 1'b1, ST_BAD_NAME},
            '{ROW_FRAME, 32'd16, 32'd0,          FILL_RAND, 1'b0, 1'b1, ST_BAD_NAME},
            '{ROW_FRAME, 32'd16, 32'hFFFF_FFFF,  FILL_RAND, 1'b0, 1'b1, ST_BAD_NAME},
            '{ROW_FRAME, 32'd16, 32'h8000_0000,  FILL_RAND, 1'b0, 1'b1, ST_BAD_NAME},
            '{ROW_FRAME, 32'd16, 32'h7FFF_FFFF,  FILL_RAND, 1'b0, 1'b1, ST_BAD_NAME},
            '{ROW_FRAME, 32'd20, 32'd4,          FILL_RAND, 1'b1, 1'b1, ST_BAD_SUM},
            // bad trailer hides a bad name length
            '{ROW_FRAME, 32'd20, 32'd40,         FILL_RAND, 1'b1, 1'b1, ST_BAD_SUM},
            '{ROW_FRAME, 32'd12, 32'd3,          FILL_ONES, 1'b0, 1'b0, ST_OK},
            // shortest legal body, leaves no room for a name
            '{ROW_LIMITS, 32'd8, 32'd64,         FILL_RAND, 1'b0, 1'b0, ST_OK},
            '{ROW_FRAME, 32'd8,  32'd2,          FILL_ZERO, 1'b0, 1'b1, ST_BAD_NAME},
            '{ROW_FRAME, 32'd8,  32'd0,          FILL_ONES, 1'b1, 1'b1, ST_BAD_SUM},
            '{ROW_FRAME, 32'd64, 32'd56,         FILL_ONES, 1'b0, 1'b1, ST_OK},
            '{ROW_FRAME, 32'd64, 32'd57,         FILL_RAND, 1'b0, 1'b1, ST_BAD_NAME}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_LIMITS) begin
                set_limits(dir_rows[i].blen[CFG_W-1:0], dir_rows[i].nlen[CFG_W-1:0]);
            end else begin
                make_frame(dir_rows[i].blen, dir_rows[i].nlen, dir_rows[i].fill,
                           dir_rows[i].spoil);
                tag_on     = dir_rows[i].typed;
                tag_status = dir_rows[i].status;
                send_bytes();
                tag_on = 1'b0;
            end
        end

        // random traffic under several limit pairs, the widest one first
        set_limits(31'd8, 31'h7FFF_FFFF);
        run_random(8, 32'h7FFF_FFFF, 280);
        set_limits(31'd20, 31'd40);
        calm = 1'b1;
        run_random(20, 40, 240);
        calm = 1'b0;
        set_limits(31'd9, 31'd300);
        run_random(9, 300, 280);

        // an out-of-bounds length kills the stream for good, so it comes last
        case ($urandom_range(4))
            0: begin
                set_limits(31'd8, 31'h7FFF_FFFF);
                bad_len = 32'h8000_0000 | $urandom;
            end
            1: begin
                set_limits(31'd8, 31'h7FFF_FFFF);
                bad_len = $urandom_range(7);
            end
            2: begin
                // minimum above maximum rejects every length
                set_limits(31'd200, 31'd100);
                bad_len = $urandom_range(200, 100);
            end
            3: begin
                set_limits(31'd8, 31'd64);
                bad_len = $urandom_range(32'h7FFF_FFFF, 65);
            end
            default: begin
                set_limits(31'd30, 31'd64);
                bad_len = $urandom_range(29, 8);
            end
        endcase
        frame_bytes.delete();
        for (int k = 0; k < HDR_BYTES; k++)
            frame_bytes.push_back(bad_len[31-8*k -: 8]);
        tag_on     = 1'b1;
        tag_status = ST_BAD_LEN;
        send_bytes();
        tag_on = 1'b0;

        // everything after that is swallowed, well-formed frames too
        make_frame(32, 5, FILL_RAND, 1'b0);
        send_bytes();
        repeat (40)
            send_byte(8'($urandom));

        s_axis_tvalid <= 1'b0;
        while (pending_status_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_status_q.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
